/* design/gda_pkg.sv */
// Shared types and constants for the Gregorian date adder.
// Holds the mode and status codes, field widths and calendar constants.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package gda_pkg;

  // field widths of the transaction payloads
  localparam int MODE_W   = 2;
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 15;
  localparam int AMOUNT_W = 12;
  localparam int STATUS_W = 2;

  // calendar limits
  localparam logic [YEAR_W-1:0]  YEAR_MAX        = 15'd32767;
  localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [MONTH_W-1:0] MONTH_FIRST     = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB       = 4'd2;
  localparam logic [DAY_W-1:0]   DAY_FIRST       = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC    = 5'd31;
  localparam logic [DAY_W:0]     DAYS_PER_WEEK   = 6'd7;

  // divisibility by 25 through the inverse of 25 modulo 2^15
  localparam logic [YEAR_W-1:0] INV25     = 15'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 15'd1310;

  // lengths of the months in a common year, January first
  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_DAY   = 2'd0,
    MODE_WEEK  = 2'd1,
    MODE_MONTH = 2'd2,
    MODE_YEAR  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_SAT     = 2'd2
  } status_t;

  // result of one pass through the step unit
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               ovf;
  } step_res_t;

endpackage

/* design/gda_if.sv */
// Valid/ready channel interfaces for the date adder.
// gda_in_if carries the start date transaction, gda_out_if the result.
// Depends on gda_pkg for field widths.
`timescale 1ns / 1ps

interface gda_in_if import gda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [DAY_W-1:0]    start_day;
  logic [MONTH_W-1:0]  start_month;
  logic [YEAR_W-1:0]   start_year;
  logic [AMOUNT_W-1:0] amount;

  modport source (output valid, mode, start_day, start_month, start_year, amount,
                  input ready);
  modport sink   (input valid, mode, start_day, start_month, start_year, amount,
                  output ready);
endinterface

interface gda_out_if import gda_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    new_day;
  logic [MONTH_W-1:0]  new_month;
  logic [YEAR_W-1:0]   new_year;
  logic [STATUS_W-1:0] status;

  modport source (output valid, new_day, new_month, new_year, status,
                  input ready);
  modport sink   (input valid, new_day, new_month, new_year, status,
                  output ready);
endinterface

/* design/gda_mlen.sv */
// Month length unit: days in a month for a given year, leap rule included.
// Returns zero for a month code outside 1 to 12.
// Depends on gda_pkg.
`timescale 1ns / 1ps

module gda_mlen import gda_pkg::*; (
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  output logic [DAY_W-1:0]   len
);

  logic [YEAR_W-1:0] prod;
  logic              div4;
  logic              div16;
  logic              div25;
  logic              leap;

  // leap: divisible by 4 and (not by 100, or by 400)
  // by 100 = by 4 and by 25; by 400 = by 16 and by 25
  assign prod  = year * INV25;
  assign div25 = (prod <= DIV25_MAX);
  assign div4  = (year[1:0] == 2'd0);
  assign div16 = (year[3:0] == 4'd0);
  assign leap  = div4 && (!div25 || div16);

  // table lookup with february patched for leap years
  always_comb begin
    if (month < MONTH_FIRST || month > MONTHS_PER_YEAR) begin
      len = '0;
    end else if (month == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end else begin
      len = MONTH_LEN[month - MONTH_FIRST];
    end
  end

endmodule

/* design/gda_step.sv */
// Shared step unit: advances a date by one day, one week or one month.
// Carries into the next month and year and flags a step past year maximum.
// Depends on gda_pkg; the month length comes from gda_mlen outside.
`timescale 1ns / 1ps

module gda_step import gda_pkg::*; (
  input  mode_t              op,
  input  logic [DAY_W-1:0]   day,
  input  logic [MONTH_W-1:0] month,
  input  logic [YEAR_W-1:0]  year,
  input  logic [DAY_W-1:0]   mlen,
  output step_res_t          res
);

  logic [DAY_W:0] sum;
  logic           roll;

  // day sum and month rollover decision
  always_comb begin
    sum  = {1'b0, day} + ((op == MODE_WEEK) ? DAYS_PER_WEEK : 6'd1);
    roll = (op == MODE_MONTH) || (op == MODE_YEAR) || (sum > {1'b0, mlen});
  end

  // next date with month and year carry
  always_comb begin
    res.day   = sum[DAY_W-1:0];
    res.month = month;
    res.year  = year;
    res.ovf   = 1'b0;
    if ((op == MODE_MONTH) || (op == MODE_YEAR)) begin
      res.day = day;
    end else if (roll) begin
      res.day = DAY_W'(sum - {1'b0, mlen});
    end
    if (roll) begin
      if (month < MONTHS_PER_YEAR) begin
        res.month = month + 4'd1;
      end else if (year < YEAR_MAX) begin
        res.month = MONTH_FIRST;
        res.year  = year + 15'd1;
      end else begin
        res.ovf = 1'b1;
      end
    end
  end

endmodule

/* design/gregorian_date_adder.sv */
// Gregorian date adder: top level with the sequencer and output register.
// Uses gda_pkg, the channel interfaces, gda_mlen and gda_step.
// One transaction in, one transaction out.
`timescale 1ns / 1ps

// Takes a start date, an amount and a mode (days, weeks, months, years) and
// returns the advanced date. A transaction passes the states check, run and
// done, with a clamp state before done in month and year mode. In run the
// shared step unit moves the date by one day, one week or one month per cycle,
// and year mode adds the amount to the year at once; an invalid start date goes
// from check to done, passed through with status invalid. A step past the last
// year ends the walk early. A result past 31 December 32767 saturates to that
// date with status saturated. The block takes a new transaction once the
// previous one has left the sequencer; the finished result waits in the output
// register, and a result that cannot enter it holds the sequencer.
module gregorian_date_adder import gda_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  gda_in_if.sink     in_ch,
  gda_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RUN,
    S_CLAMP,
    S_DONE
  } state_t;

  state_t              state_r,  state_nxt;
  mode_t               mode_r,   mode_nxt;
  logic [DAY_W-1:0]    day_r,    day_nxt;
  logic [MONTH_W-1:0]  month_r,  month_nxt;
  logic [YEAR_W-1:0]   year_r,   year_nxt;
  logic [AMOUNT_W-1:0] cnt_r,    cnt_nxt;
  status_t             stat_r,   stat_nxt;
  logic                ov_r,     ov_nxt;
  logic [DAY_W-1:0]    oday_r,   oday_nxt;
  logic [MONTH_W-1:0]  omonth_r, omonth_nxt;
  logic [YEAR_W-1:0]   oyear_r,  oyear_nxt;
  status_t             ostat_r,  ostat_nxt;

  logic [DAY_W-1:0]    mlen;
  step_res_t           step;
  logic [YEAR_W:0]     ysum;

  // month length of the working date, shared by check, step and clamp
  gda_mlen u_mlen (
    .month (month_r),
    .year  (year_r),
    .len   (mlen)
  );

  gda_step u_step (
    .op    (mode_r),
    .day   (day_r),
    .month (month_r),
    .year  (year_r),
    .mlen  (mlen),
    .res   (step)
  );

  assign ysum = {1'b0, year_r} + (YEAR_W+1)'(cnt_r);

  // handshake and result ports
  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = ov_r;
  assign out_ch.new_day   = oday_r;
  assign out_ch.new_month = omonth_r;
  assign out_ch.new_year  = oyear_r;
  assign out_ch.status    = ostat_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    cnt_nxt    = cnt_r;
    stat_nxt   = stat_r;
    ov_nxt     = ov_r;
    oday_nxt   = oday_r;
    omonth_nxt = omonth_r;
    oyear_nxt  = oyear_r;
    ostat_nxt  = ostat_r;

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt  = mode_t'(in_ch.mode);
          day_nxt   = in_ch.start_day;
          month_nxt = in_ch.start_month;
          year_nxt  = in_ch.start_year;
          cnt_nxt   = in_ch.amount;
          stat_nxt  = ST_OK;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // mlen is zero for a bad month, so the day compare covers it
        if (day_r == '0 || day_r > mlen) begin
          stat_nxt  = ST_INVALID;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (mode_r == MODE_YEAR) begin
          if (ysum[YEAR_W]) begin
            stat_nxt  = ST_SAT;
            state_nxt = S_DONE;
          end else begin
            year_nxt  = ysum[YEAR_W-1:0];
            state_nxt = S_CLAMP;
          end
        end else if (cnt_r == '0) begin
          state_nxt = (mode_r == MODE_MONTH) ? S_CLAMP : S_DONE;
        end else if (step.ovf) begin
          stat_nxt  = ST_SAT;
          state_nxt = S_DONE;
        end else begin
          day_nxt   = step.day;
          month_nxt = step.month;
          year_nxt  = step.year;
          cnt_nxt   = cnt_r - 12'd1;
        end
      end
      S_CLAMP: begin
        if (day_r > mlen) begin
          day_nxt = mlen;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt     = 1'b1;
          ostat_nxt  = stat_r;
          if (stat_r == ST_SAT) begin
            oday_nxt   = DAY_LAST_DEC;
            omonth_nxt = MONTHS_PER_YEAR;
            oyear_nxt  = YEAR_MAX;
          end else begin
            oday_nxt   = day_r;
            omonth_nxt = month_r;
            oyear_nxt  = year_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    mode_r   <= mode_nxt;
    day_r    <= day_nxt;
    month_r  <= month_nxt;
    year_r   <= year_nxt;
    cnt_r    <= cnt_nxt;
    stat_r   <= stat_nxt;
    oday_r   <= oday_nxt;
    omonth_r <= omonth_nxt;
    oyear_r  <= oyear_nxt;
    ostat_r  <= ostat_nxt;
  end

  // saturated results always carry the last representable date
  a_sat_date: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_SAT) |->
      (out_ch.new_day == DAY_LAST_DEC && out_ch.new_month == MONTHS_PER_YEAR &&
       out_ch.new_year == YEAR_MAX))
    else $error("saturated result without last date");

  // a good result has a nonzero day and a month from 1 to 12
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_OK) |->
      (out_ch.new_day != '0 && out_ch.new_month >= MONTH_FIRST &&
       out_ch.new_month <= MONTHS_PER_YEAR))
    else $error("result date out of range with status ok");

  // a new result only appears out of the final sequencer state
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_nxt && (!ov_r || out_ch.ready)) |-> (state_r == S_DONE))
    else $error("result loaded outside the done state");

endmodule

/* dv/testbench.sv */
// Self-checking testbench for gregorian_date_adder: calendar edges, random dates,
// output backpressure and drain pauses, checked against an in-bench date predictor.
// Depends on gda_pkg, gda_in_if / gda_out_if and the gregorian_date_adder RTL.
`timescale 1ns / 1ps

module testbench;
  import gda_pkg::*;

  // longest quiet stretch: a full 4095-week walk plus the long output hold
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_GAP     = 14;
  localparam int SETTLE      = 20;

  typedef struct packed {
    mode_t                mode;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [AMOUNT_W-1:0]  amount;
  } date_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    status_t              status;
  } date_res_t;

  logic clk = 1'b0;
  logic rst_n;

  gda_in_if  in_ch ();
  gda_out_if out_ch ();

  gregorian_date_adder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  date_res_t   pending_dates[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          no_idling      = 1'b0;
  bit          hold_request   = 1'b0;

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // calendar rules
  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    return MONTH_LEN[m-1];
  endfunction

  // expected date for one start transaction
  function automatic date_res_t advance_date(date_req_t r);
    int unsigned d, m, y, steps, total, ny;
    status_t     st;
    date_res_t   res;
    d  = r.day;
    m  = r.month;
    y  = r.year;
    st = ST_OK;
    if (m < 1 || m > 12 || d < 1 || d > days_in_month(m, y)) begin
      st = ST_INVALID;
    end else if (r.mode == MODE_DAY || r.mode == MODE_WEEK) begin
      steps = (r.mode == MODE_WEEK) ? r.amount * 7 : r.amount;
      while (steps > 0 && st == ST_OK) begin
        if (d < days_in_month(m, y)) begin
          d++;
        end else if (m < 12) begin
          d = 1;
          m++;
        end else if (y < YEAR_MAX) begin
          d = 1;
          m = 1;
          y++;
        end else begin
          st = ST_SAT;
        end
        steps--;
      end
    end else begin
      if (r.mode == MODE_MONTH) begin
        total = (m - 1) + r.amount;
        ny    = y + total / 12;
        m     = total % 12 + 1;
      end else begin
        ny = y + r.amount;
      end
      if (ny > YEAR_MAX) begin
        st = ST_SAT;
      end else begin
        y = ny;
        if (d > days_in_month(m, y)) d = days_in_month(m, y);
      end
    end
    if (st == ST_SAT) begin
      d = 31;
      m = 12;
      y = YEAR_MAX;
    end
    res.day    = DAY_W'(d);
    res.month  = MONTH_W'(m);
    res.year   = YEAR_W'(y);
    res.status = st;
    return res;
  endfunction

  function automatic date_req_t date_req(mode_t mode, int unsigned d, int unsigned m,
                                         int unsigned y, int unsigned amt);
    date_req_t r;
    r.mode   = mode;
    r.day    = DAY_W'(d);
    r.month  = MONTH_W'(m);
    r.year   = YEAR_W'(y);
    r.amount = AMOUNT_W'(amt);
    return r;
  endfunction

  // mostly well-formed dates, some near-invalid days and some pure noise
  function automatic date_req_t random_date_req();
    date_req_t   r;
    int unsigned pick, y, m, dim, d, amt;
    pick   = $urandom_range(0, 99);
    r.mode = mode_t'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0, 1, 2: y = $urandom_range(32700, 32767);
      3: begin
        case ($urandom_range(0, 5))
          0:       y = 0;
          1:       y = 100;
          2:       y = 400;
          3:       y = 1900;
          4:       y = 2000;
          default: y = 32767;
        endcase
      end
      default: y = $urandom_range(0, 32767);
    endcase
    m   = $urandom_range(1, 12);
    dim = days_in_month(m, y);
    d   = ($urandom_range(0, 2) == 0) ? dim : $urandom_range(1, dim);
    if (r.mode == MODE_YEAR) begin
      amt = $urandom_range(0, 4095);
    end else begin
      case ($urandom_range(0, 99))
        0, 1, 2:              amt = $urandom_range(0, 4095);
        3, 4, 5, 6, 7, 8, 9: amt = $urandom_range(0, 400);
        default:              amt = $urandom_range(0, 40);
      endcase
    end
    if (pick < 10) begin
      // noise over the whole day, month and year ranges, with a small amount
      d   = $urandom_range(0, 31);
      m   = $urandom_range(0, 15);
      y   = $urandom_range(0, 32767);
      amt = $urandom_range(0, 63);
    end else if (pick < 20) begin
      // day near, at or past the end of the month
      d = $urandom_range(28, 31);
    end
    r.day    = DAY_W'(d);
    r.month  = MONTH_W'(m);
    r.year   = YEAR_W'(y);
    r.amount = AMOUNT_W'(amt);
    return r;
  endfunction

  // offer one start transaction and wait for it to be taken
  task automatic send_date(date_req_t r);
    int unsigned gap;
    gap = no_idling ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= r.mode;
    in_ch.start_day   <= r.day;
    in_ch.start_month <= r.month;
    in_ch.start_year  <= r.year;
    in_ch.amount      <= r.amount;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
  endtask

  // one edge first so the last accepted transaction is already queued
  task automatic drain_results();
    @(posedge clk);
    wait (pending_dates.size() == 0);
    @(posedge clk);
  endtask

  // month ends, leap rules, clamps, invalid dates, saturation, extreme amounts
  task automatic test_calendar_edges();
    send_date(date_req(MODE_DAY,   15,  6,  2024,    0));
    send_date(date_req(MODE_DAY,   31,  1,  2023,    1));
    send_date(date_req(MODE_DAY,   31, 12,  2023,    1));
    send_date(date_req(MODE_DAY,   28,  2,  2024,    1));
    send_date(date_req(MODE_DAY,   28,  2,  1900,    1));
    send_date(date_req(MODE_DAY,   28,  2,     0,    1));
    send_date(date_req(MODE_DAY,    1,  1,  2000, 4095));
    send_date(date_req(MODE_WEEK,   1,  3,  2000,    1));
    send_date(date_req(MODE_WEEK,  25, 12,  1999, 4095));
    send_date(date_req(MODE_MONTH, 31,  1,  2024,    1));
    send_date(date_req(MODE_MONTH, 31,  1,  2023,    1));
    send_date(date_req(MODE_MONTH, 15, 12,  2023,    1));
    send_date(date_req(MODE_MONTH, 31,  3,   100, 4095));
    send_date(date_req(MODE_YEAR,  29,  2,  2024,    1));
    send_date(date_req(MODE_YEAR,  29,  2,  2024,    4));
    send_date(date_req(MODE_YEAR,  10, 10,     0, 4095));
    // invalid start dates pass through
    send_date(date_req(MODE_DAY,    0,  5,  2024,    3));
    send_date(date_req(MODE_MONTH,  1,  0,  2024,    3));
    send_date(date_req(MODE_YEAR,   1, 13,  2024,    1));
    send_date(date_req(MODE_WEEK,  31, 15, 32767, 4095));
    send_date(date_req(MODE_DAY,   31,  4,  2024,    1));
    send_date(date_req(MODE_YEAR,  29,  2,  1900,    1));
    // year overflow in every mode
    send_date(date_req(MODE_DAY,   31, 12, 32767,    1));
    send_date(date_req(MODE_WEEK,  30, 12, 32767,    1));
    send_date(date_req(MODE_MONTH,  1, 12, 32767,    1));
    send_date(date_req(MODE_YEAR,   1,  1, 32767,    1));
    send_date(date_req(MODE_YEAR,  31, 12, 32767,    0));
    release_input();
  endtask

  // random dates, the first stretch back to back on both sides
  task automatic test_random_dates();
    no_idling = 1'b1;
    for (int i = 0; i < 100; i++) begin
      if (i == 25) no_idling = 1'b0;
      send_date(random_date_req());
    end
    release_input();
  endtask

  // sink holds off while the source keeps offering, so the input stalls
  task automatic test_output_backpressure();
    drain_results();
    hold_request = 1'b1;
    no_idling    = 1'b1;
    for (int i = 0; i < 12; i++) send_date(random_date_req());
    release_input();
    no_idling = 1'b0;
  endtask

  // source waits for every result before each new group
  task automatic test_drain_pause();
    for (int g = 0; g < 3; g++) begin
      drain_results();
      for (int i = 0; i < 4; i++) send_date(random_date_req());
      release_input();
    end
  endtask

  // result sink with random stalls and an occasional long hold
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_idling ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid && !hold_request) @(posedge clk);
    end
  end

  // predict on each accepted start transaction, check each result transaction
  always @(posedge clk) begin : watch_channels
    date_req_t seen;
    date_res_t want;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      seen.mode   = mode_t'(in_ch.mode);
      seen.day    = in_ch.start_day;
      seen.month  = in_ch.start_month;
      seen.year   = in_ch.start_year;
      seen.amount = in_ch.amount;
      pending_dates.push_back(advance_date(seen));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result transaction: day %0d month %0d year %0d status %0d",
               out_ch.new_day, out_ch.new_month, out_ch.new_year, out_ch.status);
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        if (out_ch.new_day !== want.day) begin
          $error("new_day: expected %0d, actual %0d", want.day, out_ch.new_day);
          mismatch_count++;
        end
        if (out_ch.new_month !== want.month) begin
          $error("new_month: expected %0d, actual %0d", want.month, out_ch.new_month);
          mismatch_count++;
        end
        if (out_ch.new_year !== want.year) begin
          $error("new_year: expected %0d, actual %0d", want.year, out_ch.new_year);
          mismatch_count++;
        end
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_ch.status);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // reset, test sequence and final verdict
  initial begin
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_DAY;
    in_ch.start_day   <= '0;
    in_ch.start_month <= '0;
    in_ch.start_year  <= '0;
    in_ch.amount      <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_calendar_edges();
    test_random_dates();
    test_output_backpressure();
    test_drain_pause();

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/gda_pkg.sv
design/gda_if.sv
design/gda_mlen.sv
design/gda_step.sv
design/gregorian_date_adder.sv
dv/testbench.sv
